[sv/sysex7_pkg.sv]
package sysex7_pkg;

  // Payload bytes carried by one 7-bit system exclusive packet.
  localparam int PACKET_BYTES = 6;
  localparam int IDX_W        = $clog2(PACKET_BYTES + 1);
  localparam logic [15:0] LEN_MAX = 16'hFFFF;

  // Packet status codes.
  localparam logic [1:0] STATUS_COMPLETE = 2'd0;
  localparam logic [1:0] STATUS_START    = 2'd1;
  localparam logic [1:0] STATUS_CONT     = 2'd2;
  localparam logic [1:0] STATUS_END      = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ABORT = 2'd2;

  // Manufacturer ID parse phases.
  localparam logic [1:0] ID_PH_NONE  = 2'd0;
  localparam logic [1:0] ID_PH_EXT1  = 2'd1;
  localparam logic [1:0] ID_PH_EXT2  = 2'd2;
  localparam logic [1:0] ID_PH_READY = 2'd3;

  typedef struct packed {
    logic [1:0] packet_status;
    logic [2:0] byte_count;
    logic [6:0] payload_0;
    logic [6:0] payload_1;
    logic [6:0] payload_2;
    logic [6:0] payload_3;
    logic [6:0] payload_4;
    logic [6:0] payload_5;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [6:0]  data_value;
    logic [22:0] maker_id;
    logic [15:0] message_length;
    logic        last_of_run;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;   // load the accepted packet
    logic       clear;     // drop the collection
    logic       set_msg;   // mark a message as open
    logic       idx_clr;   // restart the byte walk
    logic       byte_go;   // consume the current payload byte
    logic       emit;      // produce a result into the pending slot
    logic [1:0] emit_kind;
    logic       finish;    // release the pending result as the last of its run
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] status;
    logic       in_msg;
    logic       over_limit;
    logic       idx_done;
    logic       byte_is_data;
    logic       can_push;
    logic       pend_vld;
    logic       out_free;
  } sts_t;

endpackage

[sv/sysex7_ctrl.sv]
module sysex7_ctrl
  import sysex7_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output cmd_t cmd,
  input  sts_t sts
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_HEAD   = 3'd1;
  localparam logic [2:0] ST_LIMIT  = 3'd2;
  localparam logic [2:0] ST_BYTES  = 3'd3;
  localparam logic [2:0] ST_TAIL   = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       starts;
  logic       ends;

  assign in_stall = (state_r != ST_IDLE);
  assign starts   = sts.status inside {STATUS_COMPLETE, STATUS_START};
  assign ends     = sts.status inside {STATUS_COMPLETE, STATUS_END};

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = ST_HEAD;
        end
      end
      ST_HEAD: begin
        if (starts && sts.in_msg) begin
          if (sts.can_push) begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = KIND_ABORT;
            cmd.clear     = 1'b1;
            state_nxt     = ST_LIMIT;
          end
        end else if (!starts && !sts.in_msg) begin
          cmd.clear = 1'b1;
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_LIMIT;
        end
      end
      ST_LIMIT: begin
        if (sts.over_limit) begin
          if (sts.can_push) begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = KIND_ABORT;
            cmd.clear     = 1'b1;
            state_nxt     = ST_FINISH;
          end
        end else begin
          cmd.idx_clr = 1'b1;
          state_nxt   = ST_BYTES;
        end
      end
      ST_BYTES: begin
        if (sts.idx_done) begin
          state_nxt = ST_TAIL;
        end else if (sts.byte_is_data) begin
          if (sts.can_push) begin
            cmd.byte_go   = 1'b1;
            cmd.emit      = 1'b1;
            cmd.emit_kind = KIND_DATA;
          end
        end else begin
          cmd.byte_go = 1'b1;
        end
      end
      ST_TAIL: begin
        if (ends) begin
          if (sts.can_push) begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = KIND_DONE;
            cmd.clear     = 1'b1;
            state_nxt     = ST_FINISH;
          end
        end else begin
          cmd.set_msg = 1'b1;
          state_nxt   = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!sts.pend_vld) begin
          state_nxt = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Every run hands its held result over before the next packet is taken.
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !sts.pend_vld)
    else $error("result still held while idle");

  a_finish_empty_exits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && !sts.pend_vld) |=> (state_r == ST_IDLE))
    else $error("finish without held result did not return to idle");

endmodule

[sv/sysex7_dp.sv]
module sysex7_dp
  import sysex7_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  in_word_t    in_data,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        out_stall,
  output logic        out_valid,
  output out_word_t   out_data,
  input  cmd_t        cmd,
  output sts_t        sts
);

  logic [1:0]       status_r, status_nxt;
  logic [IDX_W-1:0] count_r, count_nxt;
  logic [6:0]       pay_r   [PACKET_BYTES];
  logic [6:0]       pay_nxt [PACKET_BYTES];
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             in_msg_r, in_msg_nxt;
  logic [1:0]       id_phase_r, id_phase_nxt;
  logic [22:0]      maker_id_r, maker_id_nxt;
  logic [15:0]      data_cnt_r, data_cnt_nxt;
  logic [15:0]      max_r, max_nxt;
  out_word_t        pend_r, pend_nxt;
  logic             pend_vld_r, pend_vld_nxt;
  out_word_t        out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [6:0]       cur_byte;
  logic [16:0]      sum_cnt;
  logic             out_free;
  logic             push;
  in_word_t         pkt;
  logic [2:0]       raw_cnt;

  assign pkt      = in_data;
  assign raw_cnt  = pkt.byte_count;
  assign cur_byte = pay_r[idx_r];
  assign sum_cnt  = {1'b0, data_cnt_r} + 17'(count_r);
  assign out_free = !out_valid_r || !out_stall;
  assign push     = (cmd.emit || cmd.finish) && pend_vld_r;

  assign sts.status       = status_r;
  assign sts.in_msg       = in_msg_r;
  assign sts.over_limit   = (max_r != '0) && (sum_cnt > {1'b0, max_r});
  assign sts.idx_done     = (idx_r == count_r);
  assign sts.byte_is_data = (id_phase_r == ID_PH_READY);
  assign sts.can_push     = !pend_vld_r || out_free;
  assign sts.pend_vld     = pend_vld_r;
  assign sts.out_free     = out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    status_nxt   = status_r;
    count_nxt    = count_r;
    pay_nxt      = pay_r;
    idx_nxt      = idx_r;
    in_msg_nxt   = in_msg_r;
    id_phase_nxt = id_phase_r;
    maker_id_nxt = maker_id_r;
    data_cnt_nxt = data_cnt_r;
    max_nxt      = max_r;
    pend_nxt     = pend_r;
    pend_vld_nxt = pend_vld_r;
    out_nxt      = out_r;

    if (cfg_we) begin
      max_nxt = cfg_wdata;
    end

    if (cmd.capture) begin
      status_nxt = pkt.packet_status;
      count_nxt  = (raw_cnt > IDX_W'(PACKET_BYTES)) ? IDX_W'(PACKET_BYTES) : raw_cnt;
      pay_nxt[0] = pkt.payload_0;
      pay_nxt[1] = pkt.payload_1;
      pay_nxt[2] = pkt.payload_2;
      pay_nxt[3] = pkt.payload_3;
      pay_nxt[4] = pkt.payload_4;
      pay_nxt[5] = pkt.payload_5;
    end

    if (cmd.idx_clr) begin
      idx_nxt = '0;
    end

    // One payload byte feeds the ID parser or, once the ID is known, the count.
    if (cmd.byte_go) begin
      idx_nxt = idx_r + 1'b1;
      case (id_phase_r)
        ID_PH_NONE: begin
          if (cur_byte != '0) begin
            maker_id_nxt = {cur_byte, 16'd0};
            id_phase_nxt = ID_PH_READY;
          end else begin
            id_phase_nxt = ID_PH_EXT1;
          end
        end
        ID_PH_EXT1: begin
          maker_id_nxt = {8'd0, cur_byte, 8'd0};
          id_phase_nxt = ID_PH_EXT2;
        end
        ID_PH_EXT2: begin
          maker_id_nxt = {maker_id_r[22:7], cur_byte};
          id_phase_nxt = ID_PH_READY;
        end
        default: begin
          if (data_cnt_r != LEN_MAX) begin
            data_cnt_nxt = data_cnt_r + 1'b1;
          end
        end
      endcase
    end

    if (cmd.set_msg) begin
      in_msg_nxt = 1'b1;
    end

    if (cmd.clear) begin
      in_msg_nxt   = 1'b0;
      id_phase_nxt = ID_PH_NONE;
      maker_id_nxt = '0;
      data_cnt_nxt = '0;
    end

    // The held result moves out once it is known whether it ends the run.
    if (push) begin
      out_nxt             = pend_r;
      out_nxt.last_of_run = cmd.finish;
    end

    if (cmd.emit) begin
      pend_nxt.result_kind    = cmd.emit_kind;
      pend_nxt.data_value     = (cmd.emit_kind == KIND_DATA) ? cur_byte : '0;
      pend_nxt.maker_id       = (cmd.emit_kind == KIND_DONE) ? maker_id_r : '0;
      pend_nxt.message_length = (cmd.emit_kind == KIND_DONE) ? data_cnt_r : '0;
      pend_nxt.last_of_run    = 1'b0;
      pend_vld_nxt            = 1'b1;
    end else if (cmd.finish) begin
      pend_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (push) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_msg_r    <= 1'b0;
      id_phase_r  <= ID_PH_NONE;
      maker_id_r  <= '0;
      data_cnt_r  <= '0;
      max_r       <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_msg_r    <= in_msg_nxt;
      id_phase_r  <= id_phase_nxt;
      maker_id_r  <= maker_id_nxt;
      data_cnt_r  <= data_cnt_nxt;
      max_r       <= max_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    count_r  <= count_nxt;
    pay_r    <= pay_nxt;
    idx_r    <= idx_nxt;
    pend_r   <= pend_nxt;
    out_r    <= out_nxt;
  end

  // A result is only moved into the output register when that register is free.
  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> out_free)
    else $error("result pushed over an unconsumed output word");

  // Data bytes are counted only after the manufacturer ID is complete.
  a_count_after_id: assert property (@(posedge clk) disable iff (!rst_n)
    (data_cnt_r != '0) |-> (id_phase_r == ID_PH_READY))
    else $error("data counted before the ID was parsed");

endmodule

[sv/sysex7_message_collector.sv]
// 7-bit system exclusive message collector. Each input word is one decoded
// packet: a status (complete, start, continue or end), a byte count that is
// clamped to six, and six 7-bit payload bytes. The first payload bytes of a
// message form the manufacturer ID (one nonzero byte, or a zero followed by
// two more bytes); every later byte leaves the block as one data result.
// An end or complete packet yields one completion result with the ID and the
// number of data bytes. A start or complete that arrives inside an open
// message first yields an abort result for that message, and a continue or
// end outside a message is dropped without any result. When cfg_wdata has
// set a nonzero byte limit and a packet would carry the message past it
// (ID bytes count against the limit only within the packet that carries
// them), the block yields an abort, drops the collection and waits for a
// new start; with a zero limit the length saturates at 65535. One packet
// produces up to seven results, and the final result of each packet
// carries last_of_run. The block works on one packet at a time: after a
// word is accepted, in_stall stays high while the controller makes the
// order check and the limit check, walks the payload bytes and sees that
// the walk is done, yields the closing result (or marks the message open)
// and releases the last result; the next word is taken in the idle state.
// A packet that trips the limit skips the walk and the closing result, and
// a dropped packet goes from the order check straight to the release.
// Every result passes through a one-word holding slot and then the output
// register, at most one result per cycle. A stalled output holds the walk.
// Write the limit only while no packet is in flight.
module sysex7_message_collector
  import sysex7_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_data,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  // The controller sequences each packet: order check, limit check, the byte
  // walk and the closing result.
  sysex7_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  // The datapath holds the packet, the message state, the limit register and
  // the result staging.
  sysex7_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
